// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use checks on the rising edge
// of the given clock and stays quiet while the given reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cqd_pkg.sv =====
`timescale 1ns / 1ps
package cqd_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIZE_W  = 5;
  localparam int DLEN_W  = $clog2(DEPTH + 1);
  localparam int CNT_W   = (DLEN_W > SIZE_W) ? DLEN_W : SIZE_W;
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic push;
    logic pop;
    logic dump;
    logic dump_next;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
  } dp_stat_t;

endpackage

// ===== rtl/cqd_if.sv =====
`timescale 1ns / 1ps
interface cqd_cmd_if import cqd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, command, push_value, input ready);
  modport sink   (input valid, command, push_value, output ready);
endinterface

interface cqd_res_if import cqd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data;
  logic                     last;

  modport source (output valid, status, data, last, input ready);
  modport sink   (input valid, status, data, last, output ready);
endinterface

interface cqd_cfg_if import cqd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] queue_size;

  modport source (output valid, queue_size, input ready);
  modport sink   (input valid, queue_size, output ready);
endinterface

// ===== rtl/cqd_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cqd_datapath import cqd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic                     cfg_we,
  input  logic [SIZE_W-1:0]        cfg_size,
  output logic [STAT_W-1:0]        res_status,
  output logic signed [DATA_W-1:0] res_data,
  output logic                     res_last
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [SIZE_W-1:0]        size_reg;
  logic [IDX_W-1:0]         head;
  logic [IDX_W-1:0]         tail;
  logic                     empty;
  logic [IDX_W-1:0]         walk_idx;
  logic signed [DATA_W-1:0] rd_data;
  logic [STAT_W-1:0]        status;
  logic                     last;
  logic                     zero;

  logic [CNT_W-1:0] size_use;
  logic [IDX_W-1:0] tail_adv;
  logic [IDX_W-1:0] head_adv;
  logic [IDX_W-1:0] walk_adv;
  logic             full;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                          input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    return (inc >= n) ? '0 : IDX_W'(inc);
  endfunction

  // Clamp the programmed size to 1..DEPTH.
  always_comb begin
    if (size_reg == '0) begin
      size_use = CNT_W'(1);
    end else if (CNT_W'(size_reg) > CNT_W'(DEPTH)) begin
      size_use = CNT_W'(DEPTH);
    end else begin
      size_use = CNT_W'(size_reg);
    end
  end

  assign tail_adv = adv(tail, size_use);
  assign head_adv = adv(head, size_use);
  assign walk_adv = adv(walk_idx, size_use);
  assign full     = !empty && (tail_adv == head);

  assign wr_en   = cmd.push && !full;
  assign wr_addr = empty ? '0 : tail_adv;
  assign rd_en   = ((cmd.pop || cmd.dump) && !empty) || cmd.dump_next;
  assign rd_addr = cmd.dump_next ? walk_idx : head;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= push_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
      head     <= '0;
      tail     <= '0;
      empty    <= 1'b1;
      walk_idx <= '0;
    end else if (cfg_we) begin
      size_reg <= cfg_size;
      head     <= '0;
      tail     <= '0;
      empty    <= 1'b1;
    end else begin
      if (cmd.push) begin
        if (empty) begin
          head  <= '0;
          tail  <= '0;
          empty <= 1'b0;
        end else if (!full) begin
          tail <= tail_adv;
        end
      end
      if (cmd.pop && !empty) begin
        if (head == tail) begin
          head  <= '0;
          tail  <= '0;
          empty <= 1'b1;
        end else begin
          head <= head_adv;
        end
      end
      if (cmd.dump) begin
        walk_idx <= head_adv;
      end
      if (cmd.dump_next) begin
        walk_idx <= walk_adv;
      end
    end
  end

  // Result register, held until the next command.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      status <= full ? ST_OVERFLOW : ST_OK;
      zero   <= 1'b1;
      last   <= 1'b1;
    end else if (cmd.pop) begin
      status <= empty ? ST_UNDERFLOW : ST_OK;
      zero   <= empty;
      last   <= 1'b1;
    end else if (cmd.dump) begin
      status <= empty ? ST_EMPTY : ST_OK;
      zero   <= empty;
      last   <= empty || (head == tail);
    end else if (cmd.dump_next) begin
      status <= ST_OK;
      zero   <= 1'b0;
      last   <= (walk_idx == tail);
    end
  end

  assign res_status = status;
  assign res_data   = zero ? '0 : rd_data;
  assign res_last   = last;
  assign stat.last  = last;

  `ASSERT_SAME(a_empty_home, clk, rst, empty, (head == '0) && (tail == '0), "empty queue off slot zero")
  `ASSERT_SAME(a_idx_range, clk, rst, 1'b1, (CNT_W'(head) < size_use) && (CNT_W'(tail) < size_use), "index beyond size in use")
  `ASSERT_SAME(a_walk_nonempty, clk, rst, cmd.dump_next, !empty, "dump walk on empty queue")

endmodule

// ===== rtl/cqd_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cqd_ctrl import cqd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] command,
  output logic             out_valid,
  input  logic             out_ready,
  output dp_cmd_t          cmd,
  input  dp_stat_t         stat
);

  typedef enum logic {
    S_IDLE,
    S_SEND
  } state_t;

  state_t state;
  logic   accept;
  logic   known;
  logic   out_fire;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SEND);
  assign accept    = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign known     = (command == CMD_PUSH) || (command == CMD_POP) || (command == CMD_DUMP);

  always_comb begin
    cmd.push      = accept && (command == CMD_PUSH);
    cmd.pop       = accept && (command == CMD_POP);
    cmd.dump      = accept && (command == CMD_DUMP);
    cmd.dump_next = out_fire && !stat.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && known) begin
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_fire && stat.last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_dump_stream, clk, rst, out_fire && !stat.last, out_valid, "dump stream broke")
  `ASSERT_NEXT(a_done_idle, clk, rst, out_fire && stat.last, in_ready, "not idle after final item")

endmodule

// ===== rtl/circular_queue_with_dump_core.sv =====
`timescale 1ns / 1ps
// Circular FIFO of signed 32-bit words with a dump command. Each input item
// carries a command: push stores push_value at the tail (status ok, or
// overflow when full), pop returns the head value (or underflow when empty),
// dump emits every stored value head to tail with last set on the final one
// (or one queue-empty item). Command code 3 is taken and dropped. Writing
// queue_size (clamped to 1..16) empties the queue; a size write is taken only
// while the block is idle and no command item is offered. Push and pop are
// accepted, then the result register is shown on the output until taken; a
// dump streams one entry per cycle while the output is ready, from the
// single read port of the slot memory. Input is held off until every result
// of the current item has been taken. Data on push and error results reads
// as zero.
module circular_queue_with_dump_core import cqd_pkg::*; (
  input logic      clk,
  input logic      rst,
  cqd_cmd_if.sink  cmd_in,
  cqd_res_if.source res_out,
  cqd_cfg_if.sink  cfg
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     cfg_we;

  // Take size writes only while idle with no command offered, so a write
  // never lands on an item in flight or on the accept edge of a command.
  assign cfg.ready = cmd_in.ready && !cmd_in.valid;
  assign cfg_we    = cfg.valid && cfg.ready;

  // Sequencer: hold input while results drain, advance the dump walk.
  cqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_in.valid),
    .in_ready  (cmd_in.ready),
    .command   (cmd_in.command),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  // Slot memory, indices, size register and result register.
  cqd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .push_value (cmd_in.push_value),
    .cfg_we     (cfg_we),
    .cfg_size   (cfg.queue_size),
    .res_status (res_out.status),
    .res_data   (res_out.data),
    .res_last   (res_out.last)
  );

endmodule
